[rtl/core/membership_ring_table_unit_defines.svh]
// Assertion macros shared by the membership ring table checker.
// Each macro takes a label, an antecedent and a consequent; clock and reset
// are the port names i_clk and i_rst_n of the checker that uses it.
`ifndef MEMBERSHIP_RING_TABLE_UNIT_DEFINES_SVH
`define MEMBERSHIP_RING_TABLE_UNIT_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define MRT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("membership ring table check failed");

// Consequent holds in the cycle after the antecedent.
`define MRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("membership ring table check failed");

`endif

[rtl/core/mrt_pkg.sv]
// Package for the membership ring table: operation, result and entry codes,
// field widths and the stored entry type. No dependencies.
package mrt_pkg;

    localparam int ADDR_W      = 32;
    localparam int STAMP_W     = 32;
    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_FIELD_W = 132;
    localparam int OUT_TDATA_W = 136;

    // Operation codes (input tuser)
    localparam logic [1:0] MODE_JOIN  = 2'd0;
    localparam logic [1:0] MODE_LEAVE = 2'd1;
    localparam logic [1:0] MODE_DIE   = 2'd2;
    localparam logic [1:0] MODE_QUERY = 2'd3;

    // Result status codes
    localparam logic [1:0] RES_OK       = 2'd0;
    localparam logic [1:0] RES_ADDED    = 2'd1;
    localparam logic [1:0] RES_REJECTED = 2'd2;
    localparam logic [1:0] RES_FULL     = 2'd3;

    // Stored entry state codes
    localparam logic [1:0] ENT_ONLINE   = 2'd0;
    localparam logic [1:0] ENT_DEPARTED = 2'd1;
    localparam logic [1:0] ENT_DIED     = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [STAMP_W-1:0] stamp;
        logic [1:0]         state;
    } t_entry;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [STAMP_W-1:0] stamp;
    } t_member;

endpackage

[rtl/core/membership_ring_table_unit.sv]
// Membership ring table: append-only member table in one synchronous memory,
// scanned once per operation. Depends on mrt_pkg.
//
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: mode; tdata: ip, timestamp
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: status and ring neighbors
//
// An operation issues one memory read per stored entry, back to back through
// the single read port, then drains the registered read data and ends in a
// decide/write-back state. Only one operation is in flight at a time.
// Reset (synchronous, active low) empties the table; no clearing pass.
// The next item is taken while a result waits in the output register; the
// decide cycle holds only if that register is still occupied.
module membership_ring_table_unit #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] node_ip, [63:32] node_timestamp
    input  logic [mrt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] mode
    input  logic [mrt_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [1:0] status, [2] has_successor, [34:3] successor_ip,
    // [66:35] successor_stamp, [67] has_predecessor, [99:68] predecessor_ip,
    // [131:100] predecessor_stamp, [135:132] zero
    output logic [mrt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_DECIDE = 3'b100
    } t_state;

    t_state r_state, n_state;

    mrt_pkg::t_entry r_mem [TABLE_DEPTH];
    mrt_pkg::t_entry r_rd_data;

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_chk_vld;
    logic [IW-1:0] r_chk_idx;

    logic [1:0]                 r_mode;
    logic [mrt_pkg::ADDR_W-1:0]  r_ip;
    logic [mrt_pkg::STAMP_W-1:0] r_ts;

    // newest address match
    logic                        r_m_found;
    logic [IW-1:0]               r_m_idx;
    logic [mrt_pkg::STAMP_W-1:0] r_m_stamp;
    logic                        r_m_online;

    // query: exact match and online candidates around it
    logic            r_q_found;
    logic            r_fb_vld, r_lb_vld, r_sa_vld, r_la_vld;
    mrt_pkg::t_member r_fb, r_lb, r_sa, r_la;

    logic r_out_vld;
    logic [mrt_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic            issuing;
    logic            out_free;
    logic            accept;
    logic            commit;
    logic [IW-1:0]   rd_addr;
    logic            ent_match, ent_exact, ent_online;
    logic [1:0]      res_status;
    logic            want_add, do_add, do_kill;
    logic            mem_we;
    logic [IW-1:0]   wr_addr;
    mrt_pkg::t_entry wr_data;
    logic            has_succ, has_pred;
    mrt_pkg::t_member succ, pred;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_vld || m_axis_tready;
    assign issuing       = (r_state == S_SCAN) && (r_idx < r_count);
    assign rd_addr       = r_idx[IW-1:0];
    assign commit        = (r_state == S_DECIDE) && out_free;

    assign ent_match  = (r_rd_data.addr == r_ip);
    assign ent_exact  = ent_match && (r_rd_data.stamp == r_ts);
    assign ent_online = (r_rd_data.state == mrt_pkg::ENT_ONLINE);

    // Decide the result once the scan has drained.
    always_comb begin
        res_status = mrt_pkg::RES_OK;
        want_add   = 1'b0;
        do_add     = 1'b0;
        do_kill    = 1'b0;
        unique case (r_mode) inside
            mrt_pkg::MODE_JOIN: begin
                if (!r_m_found) begin
                    want_add = 1'b1;
                end else if (r_m_stamp > r_ts) begin
                    res_status = mrt_pkg::RES_REJECTED;
                end else if (r_m_stamp == r_ts) begin
                    res_status = r_m_online ? mrt_pkg::RES_OK : mrt_pkg::RES_REJECTED;
                end else if (r_m_online) begin
                    res_status = mrt_pkg::RES_REJECTED;
                end else begin
                    want_add = 1'b1;
                end
                if (want_add) begin
                    if (r_count == DEPTH_C) begin
                        res_status = mrt_pkg::RES_FULL;
                    end else begin
                        do_add     = 1'b1;
                        res_status = mrt_pkg::RES_ADDED;
                    end
                end
            end
            mrt_pkg::MODE_LEAVE, mrt_pkg::MODE_DIE: begin
                if (r_m_found && (r_m_stamp == r_ts) && r_m_online) begin
                    do_kill = 1'b1;
                end else begin
                    res_status = mrt_pkg::RES_REJECTED;
                end
            end
            mrt_pkg::MODE_QUERY: begin
                res_status = mrt_pkg::RES_OK;
            end
            default: begin
                res_status = mrt_pkg::RES_OK;
            end
        endcase
    end

    // Successor wraps to the first online entry before the match; predecessor
    // wraps to the last online entry after it.
    always_comb begin
        has_succ = 1'b0;
        has_pred = 1'b0;
        succ     = '0;
        pred     = '0;
        if ((r_mode == mrt_pkg::MODE_QUERY) && r_q_found) begin
            if (r_sa_vld) begin
                has_succ = 1'b1;
                succ     = r_sa;
            end else if (r_fb_vld) begin
                has_succ = 1'b1;
                succ     = r_fb;
            end
            if (r_lb_vld) begin
                has_pred = 1'b1;
                pred     = r_lb;
            end else if (r_la_vld) begin
                has_pred = 1'b1;
                pred     = r_la;
            end
        end
    end

    assign mem_we        = commit && (do_add || do_kill);
    assign wr_addr       = do_add ? r_count[IW-1:0] : r_m_idx;
    assign wr_data.addr  = r_ip;
    assign wr_data.stamp = r_ts;
    assign wr_data.state = do_add ? mrt_pkg::ENT_ONLINE :
                           ((r_mode == mrt_pkg::MODE_LEAVE) ? mrt_pkg::ENT_DEPARTED
                                                            : mrt_pkg::ENT_DIED);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_count = r_count;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                    n_idx   = '0;
                end
            end
            S_SCAN: begin
                if (issuing) begin
                    n_idx = r_idx + CW'(1);
                end else if (!r_chk_vld) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                    if (do_add) begin
                        n_count = r_count + CW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_chk_vld <= issuing;
            if (commit) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Operation and scan tracking
    always_ff @(posedge i_clk) begin
        r_chk_idx <= rd_addr;
        if (accept) begin
            r_mode     <= s_axis_tuser;
            r_ip       <= s_axis_tdata[31:0];
            r_ts       <= s_axis_tdata[63:32];
            r_m_found  <= 1'b0;
            r_q_found  <= 1'b0;
            r_fb_vld   <= 1'b0;
            r_lb_vld   <= 1'b0;
            r_sa_vld   <= 1'b0;
            r_la_vld   <= 1'b0;
        end else if (r_chk_vld) begin
            // forward scan: last address match is the newest
            if (ent_match) begin
                r_m_found  <= 1'b1;
                r_m_idx    <= r_chk_idx;
                r_m_stamp  <= r_rd_data.stamp;
                r_m_online <= ent_online;
            end
            if (!r_q_found && ent_exact) begin
                r_q_found <= 1'b1;
            end else if (ent_online) begin
                if (!r_q_found) begin
                    if (!r_fb_vld) begin
                        r_fb_vld <= 1'b1;
                        r_fb     <= '{addr: r_rd_data.addr, stamp: r_rd_data.stamp};
                    end
                    r_lb_vld <= 1'b1;
                    r_lb     <= '{addr: r_rd_data.addr, stamp: r_rd_data.stamp};
                end else begin
                    if (!r_sa_vld) begin
                        r_sa_vld <= 1'b1;
                        r_sa     <= '{addr: r_rd_data.addr, stamp: r_rd_data.stamp};
                    end
                    r_la_vld <= 1'b1;
                    r_la     <= '{addr: r_rd_data.addr, stamp: r_rd_data.stamp};
                end
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_data <= {4'b0000, pred.stamp, pred.addr, has_pred,
                           succ.stamp, succ.addr, has_succ, res_status};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

[rtl/core/mrt_checker.sv]
// Port-level checker for the membership ring table, bound to the top level.
// Depends on mrt_pkg and membership_ring_table_unit_defines.svh.
`include "membership_ring_table_unit_defines.svh"

module mrt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [mrt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // hold a stalled result
    `MRT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // one operation at a time: ready drops after a transfer in
    `MRT_ASSERT_NEXT(a_in_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // neighbor flags only on a query, which reports ok
    `MRT_ASSERT_SAME(a_flags_ok, m_axis_tvalid && (m_axis_tdata[1:0] != mrt_pkg::RES_OK), !m_axis_tdata[2] && !m_axis_tdata[67])

    // a missing neighbor reads as zero
    `MRT_ASSERT_SAME(a_succ_zero, m_axis_tvalid && !m_axis_tdata[2], m_axis_tdata[66:3] == '0)
    `MRT_ASSERT_SAME(a_pred_zero, m_axis_tvalid && !m_axis_tdata[67], m_axis_tdata[135:100] == '0 && m_axis_tdata[99:68] == '0)

endmodule

bind membership_ring_table_unit mrt_checker u_mrt_checker (.*);
